>>> design/bfla_pkg.sv
// Shared types, codes and default sizes for the block free list allocator.
package bfla_pkg;

   localparam int DEF_MAX_BLOCKS   = 1024;
   localparam int DEF_HEADER_BYTES = 8;

   localparam int OP_W       = 2;
   localparam int INDEX_W    = 10;
   localparam int OFFSET_W   = 26;
   localparam int COUNT_W    = 11;
   localparam int BYTES_W    = 16;
   localparam int STRIDE_W   = BYTES_W + 1;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0] MIN_BLOCKS          = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] RESET_BLOCK_COUNT   = COUNT_W'(1024);
   localparam logic [BYTES_W-1:0] RESET_BLOCK_BYTES   = BYTES_W'(64);

   typedef enum logic [OP_W-1:0] {
      OP_INIT    = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_RANGE = 2'd2,
      STS_FULL  = 2'd3
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_BLOCK_COUNT = 1'b0,
      REG_BLOCK_BYTES = 1'b1
   } csr_index_type;

   typedef struct packed {
      status_type            status;
      logic [INDEX_W-1:0]    granted_index;
      logic [OFFSET_W-1:0]   byte_offset;
      logic [COUNT_W-1:0]    free_blocks;
      logic                  is_empty;
      logic                  is_full;
   } rsp_type;

endpackage

>>> design/bfla_link_mem.sv
// Link memory holding the next pointer of every block, one write and one read port.
module bfla_link_mem #(
   parameter int DEPTH  = bfla_pkg::DEF_MAX_BLOCKS,
   parameter int DATA_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);
   import bfla_pkg::*;

   logic [DATA_W-1:0] link_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bfla_ctrl.sv
// Sequencer for initialize, allocate and release, holding the list head and free count.
module bfla_ctrl #(
   parameter int MAX_BLOCKS   = bfla_pkg::DEF_MAX_BLOCKS,
   parameter int HEADER_BYTES = bfla_pkg::DEF_HEADER_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bfla_pkg::OP_W-1:0]           req_operation,
   input  logic [bfla_pkg::INDEX_W-1:0]        req_block_index,
   input  logic [$clog2(MAX_BLOCKS + 1)-1:0]   usable_count,
   input  logic [bfla_pkg::BYTES_W-1:0]        block_bytes,
   output bfla_pkg::rsp_type                   result,
   output logic                                result_valid,
   input  logic                                result_ready,
   output logic                                mem_wr_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]       mem_wr_addr,
   output logic [$clog2(MAX_BLOCKS + 1)-1:0]   mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]       mem_rd_addr,
   input  logic [$clog2(MAX_BLOCKS + 1)-1:0]   mem_rd_data
);
   import bfla_pkg::*;

   localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int PROD_W = IDX_W + STRIDE_W;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_INIT   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [LINK_W-1:0]  free_ff, free_in;
   status_type         status_ff, status_in;
   logic               pop_ff, pop_in;
   logic [IDX_W-1:0]   granted_ff, granted_in;
   logic [PROD_W-1:0]  product_ff, product_in;
   logic [IDX_W-1:0]   init_idx_ff, init_idx_in;
   logic [STRIDE_W-1:0] stride;
   logic [LINK_W-1:0]  init_next;
   logic               accept;

   assign stride    = STRIDE_W'(block_bytes) + STRIDE_W'(HEADER_BYTES);
   assign init_next = LINK_W'(init_idx_ff) + LINK_W'(1);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      free_in     = free_ff;
      status_in   = status_ff;
      pop_in      = pop_ff;
      granted_in  = granted_ff;
      product_in  = product_ff;
      init_idx_in = init_idx_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = init_idx_ff;
      mem_wr_data = head_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = IDX_W'(head_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_FINISH;
               status_in = STS_OK;
               pop_in    = 1'b0;
               unique case (req_operation)
                  OP_INIT: begin
                     head_in     = (usable_count != '0) ? '0 : NULL_LINK;
                     free_in     = usable_count;
                     init_idx_in = '0;
                     if (usable_count != '0) begin
                        state_in = ST_INIT;
                     end
                  end
                  OP_ALLOC: begin
                     if (free_ff == '0 || head_ff >= NULL_LINK) begin
                        status_in = STS_EMPTY;
                     end else begin
                        mem_rd_en  = 1'b1;
                        granted_in = IDX_W'(head_ff);
                        product_in = PROD_W'(IDX_W'(head_ff)) * PROD_W'(stride);
                        free_in    = free_ff - LINK_W'(1);
                        pop_in     = 1'b1;
                     end
                  end
                  OP_RELEASE: begin
                     if (32'(req_block_index) >= 32'(usable_count)) begin
                        status_in = STS_RANGE;
                     end else if (free_ff >= usable_count) begin
                        status_in = STS_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = IDX_W'(req_block_index);
                        mem_wr_data = head_ff;
                        head_in     = LINK_W'(req_block_index);
                        free_in     = free_ff + LINK_W'(1);
                     end
                  end
                  default: begin
                     status_in = STS_OK;
                  end
               endcase
            end
         end
         ST_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = init_idx_ff;
            mem_wr_data = (init_next < usable_count) ? init_next : NULL_LINK;
            init_idx_in = init_idx_ff + IDX_W'(1);
            if (init_next == usable_count) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (result_ready) begin
               state_in = ST_IDLE;
               if (pop_ff) begin
                  head_in = mem_rd_data;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      result_valid         = (state_ff == ST_FINISH);
      result.status        = status_ff;
      result.granted_index = pop_ff ? INDEX_W'(granted_ff) : '0;
      result.byte_offset   = pop_ff ? OFFSET_W'(product_ff + PROD_W'(HEADER_BYTES)) : '0;
      result.free_blocks   = COUNT_W'(free_ff);
      result.is_empty      = (free_ff == '0);
      result.is_full       = (free_ff == usable_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= NULL_LINK;
         free_ff  <= '0;
         pop_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         pop_ff   <= pop_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      product_ff  <= product_in;
      init_idx_ff <= init_idx_in;
   end

`ifndef ASSERT_OFF
   a_one_port_op: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("link memory read and write in the same cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("sequencer idle right after taking a word");

   a_read_means_pop: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |=> (state_ff == ST_FINISH) && pop_ff)
      else $error("link read without a pending pop");

   a_empty_alloc: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_ALLOC && free_ff == '0)
      |=> (status_ff == STS_EMPTY) && !pop_ff)
      else $error("allocate on an empty pool not reported as empty");
`endif

endmodule

>>> design/block_free_list_allocator.sv
// Allocate, release and no-op words pass from the sequencer's result registers into the output register.
// Initialize writes one link entry per cycle, one for each block of the effective block count.
// One word is in work at a time, so a new word is taken only once the last has left the sequencer.
// A finished result waits in the output register while the next word is taken; a stalled
// full output register holds the sequencer and stalls the input.
// Synchronous reset empties the free list, restores the count and size registers and leaves links unset.
module block_free_list_allocator #(
   parameter int MAX_BLOCKS   = bfla_pkg::DEF_MAX_BLOCKS,
   parameter int HEADER_BYTES = bfla_pkg::DEF_HEADER_BYTES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bfla_pkg::OP_W-1:0]          req_operation,
   input  logic [bfla_pkg::INDEX_W-1:0]       req_block_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [bfla_pkg::INDEX_W-1:0]       rsp_granted_index,
   output logic [bfla_pkg::OFFSET_W-1:0]      rsp_byte_offset,
   output logic [bfla_pkg::COUNT_W-1:0]       rsp_free_blocks,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   input  logic                               csr_wr_en,
   input  logic [bfla_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [bfla_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import bfla_pkg::*;

   localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W  = $clog2(MAX_BLOCKS);

   logic [COUNT_W-1:0] block_count_ff, block_count_in;
   logic [BYTES_W-1:0] block_bytes_ff, block_bytes_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [LINK_W-1:0]  usable_count;
   rsp_type            result;
   logic               result_valid;
   logic               out_free;

   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [LINK_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [LINK_W-1:0]  mem_rd_data;

   always_comb begin
      block_count_in = block_count_ff;
      block_bytes_in = block_bytes_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_BLOCK_COUNT: block_count_in = COUNT_W'(csr_wr_data);
            REG_BLOCK_BYTES: block_bytes_in = BYTES_W'(csr_wr_data);
            default:         block_count_in = block_count_ff;
         endcase
      end
   end

   always_comb begin
      if (block_count_ff < MIN_BLOCKS || block_bytes_ff == '0) begin
         usable_count = '0;
      end else if (32'(block_count_ff) > 32'(MAX_BLOCKS)) begin
         usable_count = LINK_W'(MAX_BLOCKS);
      end else begin
         usable_count = LINK_W'(block_count_ff);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= RESET_BLOCK_COUNT;
         block_bytes_ff <= RESET_BLOCK_BYTES;
         rsp_valid_ff   <= 1'b0;
      end else begin
         block_count_ff <= block_count_in;
         block_bytes_ff <= block_bytes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   bfla_ctrl #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_block_index (req_block_index),
      .usable_count    (usable_count),
      .block_bytes     (block_bytes_ff),
      .result          (result),
      .result_valid    (result_valid),
      .result_ready    (out_free),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   bfla_link_mem #(
      .DEPTH  (MAX_BLOCKS),
      .DATA_W (LINK_W)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_granted_index = rsp_data_ff.granted_index;
   assign rsp_byte_offset   = rsp_data_ff.byte_offset;
   assign rsp_free_blocks   = rsp_data_ff.free_blocks;
   assign rsp_is_empty      = rsp_data_ff.is_empty;
   assign rsp_is_full       = rsp_data_ff.is_full;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the block free list allocator: directed table, then random phases.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bfla_pkg::*;

   localparam int unsigned POOL_MAX    = DEF_MAX_BLOCKS;
   localparam int unsigned HEADER      = DEF_HEADER_BYTES;
   localparam int unsigned NULL_BLK    = POOL_MAX;
   localparam int unsigned RANDOM_WORDS = 1400;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic                 is_write;
      csr_index_type        reg_sel;
      logic [CSR_DATA_W-1:0] value;
      logic [OP_W-1:0]      op;
      logic [INDEX_W-1:0]   index;
      logic                 typed;
      rsp_type              want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_operation = '0;
   logic [INDEX_W-1:0]    req_block_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [INDEX_W-1:0]    rsp_granted_index;
   logic [OFFSET_W-1:0]   rsp_byte_offset;
   logic [COUNT_W-1:0]    rsp_free_blocks;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // Shadow of the pool: link memory, list head, free count and the two registers.
   int unsigned           link_mem [POOL_MAX];
   int unsigned           head_blk = NULL_BLK;
   int unsigned           free_cnt = 0;
   logic [COUNT_W-1:0]    cfg_count = RESET_BLOCK_COUNT;
   logic [BYTES_W-1:0]    cfg_bytes = RESET_BLOCK_BYTES;

   rsp_type               pending_replies[$];
   logic [INDEX_W-1:0]    held_blocks[$];
   bit                    calm = 1'b0;
   int unsigned           stall_left = 0;
   int unsigned           cycles_run = 0;
   int unsigned           mismatches = 0;
   int unsigned           results_checked = 0;
   int unsigned           words_sent = 0;
   int unsigned           inits_sent = 0;
   int unsigned           register_writes = 0;
   int unsigned           status_seen [4] = '{default: 0};

   block_free_list_allocator i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_free_blocks   (rsp_free_blocks),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   function automatic int unsigned pool_size();
      if (cfg_count < MIN_BLOCKS || cfg_bytes == '0) return 0;
      if (cfg_count > POOL_MAX) return POOL_MAX;
      return int'(cfg_count);
   endfunction

   function automatic rsp_type pool_step(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx);
      rsp_type     r;
      int unsigned cnt;
      int unsigned blk;
      cnt = pool_size();
      r = '0;
      case (op)
         OP_INIT: begin
            for (blk = 0; blk < cnt; blk++) begin
               link_mem[blk] = (blk + 1 < cnt) ? blk + 1 : NULL_BLK;
            end
            head_blk = (cnt > 0) ? 0 : NULL_BLK;
            free_cnt = cnt;
         end
         OP_ALLOC: begin
            if (free_cnt == 0 || head_blk >= POOL_MAX) begin
               r.status = STS_EMPTY;
            end else begin
               r.granted_index = INDEX_W'(head_blk);
               r.byte_offset = OFFSET_W'(head_blk * (32'(cfg_bytes) + HEADER) + HEADER);
               head_blk = link_mem[head_blk];
               if (head_blk > POOL_MAX) head_blk = NULL_BLK;
               free_cnt--;
            end
         end
         OP_RELEASE: begin
            if (int'(idx) >= cnt) begin
               r.status = STS_RANGE;
            end else if (free_cnt >= cnt) begin
               r.status = STS_FULL;
            end else begin
               link_mem[idx] = head_blk;
               head_blk = int'(idx);
               free_cnt++;
            end
         end
         default: ;
      endcase
      r.free_blocks = COUNT_W'(free_cnt);
      r.is_empty = (free_cnt == 0);
      r.is_full = (free_cnt == cnt);
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic plan_row_type csr_row(csr_index_type sel, logic [CSR_DATA_W-1:0] value);
      plan_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.reg_sel = sel;
      row.value = value;
      return row;
   endfunction

   function automatic plan_row_type free_row(logic [OP_W-1:0] op, int unsigned idx);
      plan_row_type row;
      row = '0;
      row.op = op;
      row.index = INDEX_W'(idx);
      return row;
   endfunction

   function automatic plan_row_type fixed_row(logic [OP_W-1:0] op, int unsigned idx,
                                              status_type s, int unsigned granted,
                                              int unsigned offset, int unsigned free_left,
                                              bit empty, bit full);
      plan_row_type row;
      row = free_row(op, idx);
      row.typed = 1'b1;
      row.want.status = s;
      row.want.granted_index = INDEX_W'(granted);
      row.want.byte_offset = OFFSET_W'(offset);
      row.want.free_blocks = COUNT_W'(free_left);
      row.want.is_empty = empty;
      row.want.is_full = full;
      return row;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at result %0d: %s", results_checked, msg);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type sel, logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_wr_en = 1'b1;
      csr_index = sel;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (sel == REG_BLOCK_COUNT) cfg_count = value[COUNT_W-1:0];
      else cfg_bytes = value;
      register_writes++;
   endtask

   task automatic send_word(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx, bit typed,
                            rsp_type fixed);
      rsp_type     predicted;
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_block_index = idx;
      do @(posedge clock); while (req_stall);
      predicted = pool_step(op, idx);
      pending_replies.push_back(typed ? fixed : predicted);
      words_sent++;
      if (op == OP_INIT) begin
         inits_sent++;
         held_blocks.delete();
      end else if (op == OP_ALLOC && predicted.status == STS_OK) begin
         held_blocks.push_back(predicted.granted_index);
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_replies
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (pending_replies.size() == 0) begin
            report_mismatch("result word arrived with nothing outstanding");
         end else begin
            want = pending_replies.pop_front();
            status_seen[want.status]++;
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_granted_index !== want.granted_index)
               report_mismatch($sformatf("granted_index %0d, expected %0d",
                                         rsp_granted_index, want.granted_index));
            if (rsp_byte_offset !== want.byte_offset)
               report_mismatch($sformatf("byte_offset %0d, expected %0d",
                                         rsp_byte_offset, want.byte_offset));
            if (rsp_free_blocks !== want.free_blocks)
               report_mismatch($sformatf("free_blocks %0d, expected %0d",
                                         rsp_free_blocks, want.free_blocks));
            if (rsp_is_empty !== want.is_empty)
               report_mismatch($sformatf("is_empty %0b, expected %0b",
                                         rsp_is_empty, want.is_empty));
            if (rsp_is_full !== want.is_full)
               report_mismatch($sformatf("is_full %0b, expected %0b",
                                         rsp_is_full, want.is_full));
         end
      end
   end

   initial begin : watchdog
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("Run stopped after %0d cycles with %0d words outstanding",
               cycles_run, pending_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      plan_row_type       plan[$];
      int unsigned        item;
      int unsigned        phase_len;
      int unsigned        alloc_cut;
      int unsigned        pick;
      int unsigned        sel;
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0] value;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      plan.push_back(csr_row(REG_BLOCK_BYTES, 16'hFFFF));
      plan.push_back(fixed_row(OP_ALLOC, 0, STS_EMPTY, 0, 0, 0, 1, 0));
      plan.push_back(fixed_row(OP_RELEASE, 1023, STS_OK, 0, 0, 1, 0, 0));
      plan.push_back(fixed_row(OP_ALLOC, 0, STS_OK, 1023, 67050497, 0, 1, 0));
      plan.push_back(fixed_row(OP_UNUSED, 1023, STS_OK, 0, 0, 0, 1, 0));
      plan.push_back(fixed_row(OP_INIT, 0, STS_OK, 0, 0, 1024, 0, 1));
      plan.push_back(fixed_row(OP_RELEASE, 5, STS_FULL, 0, 0, 1024, 0, 1));
      plan.push_back(fixed_row(OP_ALLOC, 0, STS_OK, 0, 8, 1023, 0, 0));
      plan.push_back(fixed_row(OP_ALLOC, 0, STS_OK, 1, 65551, 1022, 0, 0));
      plan.push_back(free_row(OP_RELEASE, 1023));
      plan.push_back(free_row(OP_ALLOC, 0));
      plan.push_back(csr_row(REG_BLOCK_COUNT, 16'd2));
      plan.push_back(free_row(OP_RELEASE, 2));
      plan.push_back(fixed_row(OP_INIT, 0, STS_OK, 0, 0, 2, 0, 1));
      plan.push_back(fixed_row(OP_ALLOC, 0, STS_OK, 0, 8, 1, 0, 0));
      plan.push_back(fixed_row(OP_ALLOC, 0, STS_OK, 1, 65551, 0, 1, 0));
      plan.push_back(fixed_row(OP_ALLOC, 0, STS_EMPTY, 0, 0, 0, 1, 0));
      plan.push_back(free_row(OP_RELEASE, 1));
      plan.push_back(csr_row(REG_BLOCK_COUNT, 16'd1));
      plan.push_back(free_row(OP_RELEASE, 0));
      plan.push_back(fixed_row(OP_INIT, 0, STS_OK, 0, 0, 0, 1, 1));
      plan.push_back(fixed_row(OP_ALLOC, 0, STS_EMPTY, 0, 0, 0, 1, 1));
      plan.push_back(csr_row(REG_BLOCK_COUNT, 16'd2047));
      plan.push_back(csr_row(REG_BLOCK_BYTES, 16'd0));
      plan.push_back(fixed_row(OP_INIT, 0, STS_OK, 0, 0, 0, 1, 1));
      plan.push_back(csr_row(REG_BLOCK_BYTES, 16'd1));
      plan.push_back(fixed_row(OP_INIT, 0, STS_OK, 0, 0, 1024, 0, 1));
      plan.push_back(free_row(OP_ALLOC, 0));
      plan.push_back(free_row(OP_RELEASE, 7));
      plan.push_back(free_row(OP_ALLOC, 0));

      foreach (plan[k]) begin
         if (plan[k].is_write) write_register(plan[k].reg_sel, plan[k].value);
         else send_word(plan[k].op, plan[k].index, plan[k].typed, plan[k].want);
      end

      item = 0;
      while (item < RANDOM_WORDS) begin
         sel = $urandom_range(0, 19);
         if (sel < 12) value = 16'($urandom_range(2, 24));
         else if (sel < 14) value = 16'($urandom_range(0, 1));
         else if (sel < 17) value = 16'($urandom_range(25, 1024));
         else if (sel < 19) value = 16'($urandom_range(1025, 2047));
         else value = 16'(POOL_MAX);
         if ($urandom_range(0, 3) != 0) write_register(REG_BLOCK_COUNT, value);
         sel = $urandom_range(0, 9);
         if (sel == 0) value = '0;
         else if (sel == 1) value = 16'hFFFF;
         else if (sel < 4) value = 16'd1;
         else value = 16'($urandom_range(1, 65535));
         if ($urandom_range(0, 2) == 0) write_register(REG_BLOCK_BYTES, value);
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) != 0) begin
            send_word(OP_INIT, 10'($urandom_range(0, 1023)), 1'b0, '0);
            item++;
         end
         phase_len = $urandom_range(40, 120);
         alloc_cut = $urandom_range(30, 75);
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            idx = 10'($urandom_range(0, 1023));
            if (pick < 2) begin
               op = OP_INIT;
            end else if (pick < 4) begin
               op = OP_UNUSED;
            end else if (pick < alloc_cut) begin
               op = OP_ALLOC;
            end else begin
               op = OP_RELEASE;
               sel = $urandom_range(0, 9);
               if (sel < 6 && held_blocks.size() > 0) begin
                  pick = $urandom_range(0, held_blocks.size() - 1);
                  idx = held_blocks[pick];
                  held_blocks.delete(pick);
               end else if (sel < 8) begin
                  idx = 10'($urandom_range(0, pool_size() > 0 ? pool_size() - 1 : 0));
               end
            end
            send_word(op, idx, 1'b0, '0);
            item++;
            if ($urandom_range(0, 199) == 0) wait_drained();
         end
      end

      calm = 1'b0;
      wait_drained();
      repeat (8) @(negedge clock);
      if (pending_replies.size() != 0)
         report_mismatch($sformatf("%0d words never answered", pending_replies.size()));

      $display("Covered %0d words (%0d initializations) over %0d register writes; %0d results.",
               words_sent, inits_sent, register_writes, results_checked);
      $display("Status mix: ok %0d, empty %0d, out of range %0d, already full %0d.",
               status_seen[STS_OK], status_seen[STS_EMPTY], status_seen[STS_RANGE],
               status_seen[STS_FULL]);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/bfla_pkg.sv
design/bfla_link_mem.sv
design/bfla_ctrl.sv
design/block_free_list_allocator.sv
tb/sv/tb.sv
